// File: rtl/sccd_pkg.sv
package sccd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned RomAw = 7;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [RomAw-1:0] rom_addr_t;

  typedef struct packed {
    logic  hit;
    byte_t code;
  } sym_t;

  localparam byte_t REL_MASK     = 8'h80;
  localparam byte_t REL_LSHIFT   = 8'hAA;
  localparam byte_t REL_RSHIFT   = 8'hB6;
  localparam byte_t REL_CTRL     = 8'h9D;
  localparam byte_t KEY_CAPS     = 8'h3A;
  localparam byte_t KEY_CTRL     = 8'h1D;
  localparam byte_t KEY_LSHIFT   = 8'h2A;
  localparam byte_t KEY_RSHIFT   = 8'h36;
  localparam byte_t KEY_UP       = 8'h48;
  localparam byte_t KEY_LEFT     = 8'h4B;
  localparam byte_t KEY_RIGHT    = 8'h4D;
  localparam byte_t KEY_DOWN     = 8'h50;
  localparam byte_t KEY_ESC      = 8'h01;
  localparam byte_t KEY_ALT      = 8'h38;
  localparam byte_t CHR_UP       = 8'h0C;
  localparam byte_t CHR_LOWER_A  = 8'd97;
  localparam byte_t CHR_LOWER_Z  = 8'd122;
  localparam byte_t CASE_OFFSET  = 8'd32;

  function automatic byte_t layout_rom(input rom_addr_t a);
    byte_t v;
    v = 8'h00;
    case (a)
      7'd1:  v = 8'h1B;
      7'd2:  v = 8'h31;
      7'd3:  v = 8'h32;
      7'd4:  v = 8'h33;
      7'd5:  v = 8'h34;
      7'd6:  v = 8'h35;
      7'd7:  v = 8'h36;
      7'd8:  v = 8'h37;
      7'd9:  v = 8'h38;
      7'd10: v = 8'h39;
      7'd11: v = 8'h30;
      7'd12: v = 8'h27;
      7'd13: v = 8'h60;
      7'd14: v = 8'h11;
      7'd15: v = 8'h09;
      7'd16: v = 8'h71;
      7'd17: v = 8'h77;
      7'd18: v = 8'h65;
      7'd19: v = 8'h72;
      7'd20: v = 8'h74;
      7'd21: v = 8'h79;
      7'd22: v = 8'h75;
      7'd23: v = 8'h69;
      7'd24: v = 8'h6F;
      7'd25: v = 8'h70;
      7'd26: v = 8'h5B;
      7'd27: v = 8'h5D;
      7'd28: v = 8'h10;
      7'd30: v = 8'h61;
      7'd31: v = 8'h73;
      7'd32: v = 8'h64;
      7'd33: v = 8'h66;
      7'd34: v = 8'h67;
      7'd35: v = 8'h68;
      7'd36: v = 8'h6A;
      7'd37: v = 8'h6B;
      7'd38: v = 8'h6C;
      7'd39: v = 8'h40;
      7'd40: v = 8'h23;
      7'd41: v = 8'h5C;
      7'd43: v = 8'hA7;
      7'd44: v = 8'h7A;
      7'd45: v = 8'h78;
      7'd46: v = 8'h63;
      7'd47: v = 8'h76;
      7'd48: v = 8'h62;
      7'd49: v = 8'h6E;
      7'd50: v = 8'h6D;
      7'd51: v = 8'h2C;
      7'd52: v = 8'h2E;
      7'd53: v = 8'h2D;
      7'd55: v = 8'h2A;
      7'd57: v = 8'h20;
      7'd59: v = 8'h01;
      7'd60: v = 8'h02;
      7'd61: v = 8'h03;
      7'd62: v = 8'h04;
      7'd63: v = 8'h05;
      7'd64: v = 8'h06;
      7'd65: v = 8'h07;
      7'd66: v = 8'h38;
      7'd67: v = 8'h39;
      7'd68: v = 8'h08;
      7'd72: v = 8'h0C;
      7'd74: v = 8'h2D;
      7'd78: v = 8'h2B;
      7'd87: v = 8'h09;
      7'd88: v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic sym_t shifted_symbol(input byte_t v);
    sym_t s;
    s.hit  = 1'b1;
    s.code = 8'h00;
    case (v)
      8'h30: s.code = 8'h3D;
      8'h31: s.code = 8'h21;
      8'h32: s.code = 8'h22;
      8'h33: s.code = 8'hA3;
      8'h34: s.code = 8'h24;
      8'h35: s.code = 8'h25;
      8'h36: s.code = 8'h26;
      8'h37: s.code = 8'h2F;
      8'h38: s.code = 8'h28;
      8'h39: s.code = 8'h29;
      8'h27: s.code = 8'h3F;
      8'h60: s.code = 8'h5E;
      8'h2C: s.code = 8'h3B;
      8'h2E: s.code = 8'h3A;
      8'h2D: s.code = 8'h5F;
      8'h5C: s.code = 8'h7C;
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/scancode_to_char_decoder_unit.sv
// Scancode set 1 keyboard decoder.
// Input channel: in_valid, in_stall, in_scan_byte carry one raw scancode byte
// per transaction. Bit 7 set marks a key release.
// Output channel: out_valid, out_stall, out_char_code carry one character
// byte per transaction. Modifier keys, releases and silent keys produce no
// output transaction; every other press produces at most one, and held shift
// or ctrl can suppress it.
// A byte is captured in an input register, decoded against the layout ROM
// and the shift, ctrl and caps lock flags combinationally, and written to the
// output register, so a character passes the input and output registers
// before out_valid; one byte per cycle is accepted while in_stall is low.
// If the receiver stalls a pending character while the input register holds
// a byte, the byte waits and in_stall rises until the output register frees.
// Synchronous reset (rst_n low) empties both registers and clears the
// shift, ctrl and caps lock flags.
module scancode_to_char_decoder_unit
  import sccd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_code
);

  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;
  logic  shift_r, shift_nxt;
  logic  ctrl_r, ctrl_nxt;
  logic  caps_r, caps_nxt;
  logic  out_valid_r, out_valid_nxt;
  byte_t out_char_code_r, out_char_code_nxt;

  logic  out_free;
  logic  s1_go;
  logic  in_acc;
  logic  emit;
  byte_t emit_code;
  byte_t rom_v;
  sym_t  sym;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign rom_v = layout_rom(s1_byte_r[RomAw-1:0]);
  assign sym   = shifted_symbol(rom_v);

  always_comb begin
    emit      = 1'b0;
    emit_code = rom_v;
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    caps_nxt  = caps_r;
    if ((s1_byte_r & REL_MASK) != 8'h00) begin
      if (s1_byte_r == REL_LSHIFT || s1_byte_r == REL_RSHIFT) begin
        shift_nxt = 1'b0;
      end else if (s1_byte_r == REL_CTRL) begin
        ctrl_nxt = 1'b0;
      end
    end else begin
      unique case (s1_byte_r) inside
        KEY_LEFT, KEY_RIGHT, KEY_DOWN, KEY_ESC, KEY_ALT: begin
          emit = 1'b0;
        end
        KEY_UP: begin
          emit      = 1'b1;
          emit_code = CHR_UP;
        end
        KEY_CTRL: begin
          ctrl_nxt = 1'b1;
        end
        KEY_LSHIFT, KEY_RSHIFT: begin
          shift_nxt = 1'b1;
        end
        KEY_CAPS: begin
          caps_nxt = !caps_r;
        end
        default: begin
          if ((shift_r || caps_r) && rom_v >= CHR_LOWER_A && rom_v <= CHR_LOWER_Z) begin
            emit      = 1'b1;
            emit_code = rom_v - CASE_OFFSET;
          end else if (shift_r) begin
            emit      = sym.hit;
            emit_code = sym.code;
          end else if (!ctrl_r) begin
            emit = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt      = s1_valid_r;
    out_valid_nxt     = out_valid_r;
    out_char_code_nxt = out_char_code_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
      if (emit) begin
        out_valid_nxt     = 1'b1;
        out_char_code_nxt = emit_code;
      end
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      shift_r     <= 1'b0;
      ctrl_r      <= 1'b0;
      caps_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        shift_r <= shift_nxt;
        ctrl_r  <= ctrl_nxt;
        caps_r  <= caps_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_scan_byte;
    end
    out_char_code_r <= out_char_code_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;

  a_up_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_byte_r == KEY_UP |=> out_valid_r && out_char_code_r == CHR_UP)
    else $error("Up arrow press did not produce its control character.");

  a_release_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_byte_r[7] |=> !out_valid_r)
    else $error("A key release produced an output transaction.");

  a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_byte_r == KEY_CAPS |=> caps_r != $past(caps_r))
    else $error("Caps lock press did not toggle the caps lock flag.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("Input stalled while the pipeline could advance.");

endmodule

// File: test/tb_scancode_to_char_decoder_unit.sv
module tb_scancode_to_char_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sccd_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_e;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned PRINT_CAP   = 40;

  localparam byte_t KEY_MAP [128] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h27, 8'h60, 8'h11, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h10, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h40,
    8'h23, 8'h5C, 8'h00, 8'hA7, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h01,
    8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h38, 8'h39, 8'h08, 8'h00,
    8'h00, 8'h00, 8'h0C, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h0A, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam byte_t DIRECTED_KEYS [28] = '{
    8'h00, 8'h1E, 8'h02, KEY_UP, KEY_LEFT, KEY_RIGHT, KEY_DOWN, KEY_ESC, KEY_ALT,
    KEY_LSHIFT, 8'h1E, 8'h04, 8'h0F, REL_LSHIFT,
    KEY_RSHIFT, 8'h29, REL_RSHIFT,
    KEY_CAPS, 8'h2C, 8'h2B, KEY_CTRL, 8'h1E, KEY_CAPS, 8'h1E, KEY_UP, REL_CTRL,
    8'hFF, 8'h7F
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_scan_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char_code;

  logic        shift_q = 1'b0;
  logic        ctrl_q = 1'b0;
  logic        caps_q = 1'b0;
  byte_t       char_expect_q [$];
  byte_t       exp_char;

  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_max = 0;
  int unsigned burst_max = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned pat_cnt = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic        hold_req = 1'b0;

  scancode_to_char_decoder_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_scan_byte (in_scan_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit shifted_char(input byte_t v, output byte_t ch);
    ch = 8'h00;
    case (v)
      8'h30: ch = 8'h3D;
      8'h31: ch = 8'h21;
      8'h32: ch = 8'h22;
      8'h33: ch = 8'hA3;
      8'h34: ch = 8'h24;
      8'h35: ch = 8'h25;
      8'h36: ch = 8'h26;
      8'h37: ch = 8'h2F;
      8'h38: ch = 8'h28;
      8'h39: ch = 8'h29;
      8'h27: ch = 8'h3F;
      8'h60: ch = 8'h5E;
      8'h2C: ch = 8'h3B;
      8'h2E: ch = 8'h3A;
      8'h2D: ch = 8'h5F;
      8'h5C: ch = 8'h7C;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Updates the modifier flags and returns whether the scancode yields a character.
  function automatic bit decode_scan(input byte_t code, output byte_t ch);
    byte_t v;
    ch = 8'h00;
    if ((code & REL_MASK) != 8'h00) begin
      if (code == REL_LSHIFT || code == REL_RSHIFT) begin
        shift_q = 1'b0;
      end else if (code == REL_CTRL) begin
        ctrl_q = 1'b0;
      end
      return 1'b0;
    end
    case (code)
      KEY_LEFT, KEY_RIGHT, KEY_DOWN, KEY_ESC, KEY_ALT: return 1'b0;
      KEY_UP: begin
        ch = CHR_UP;
        return 1'b1;
      end
      KEY_CTRL: begin
        ctrl_q = 1'b1;
        return 1'b0;
      end
      KEY_LSHIFT, KEY_RSHIFT: begin
        shift_q = 1'b1;
        return 1'b0;
      end
      KEY_CAPS: begin
        caps_q = !caps_q;
        return 1'b0;
      end
      default: ;
    endcase
    v = KEY_MAP[code[6:0]];
    if ((shift_q || caps_q) && v >= CHR_LOWER_A && v <= CHR_LOWER_Z) begin
      ch = v - CASE_OFFSET;
      return 1'b1;
    end
    if (shift_q) begin
      return shifted_char(v, ch);
    end
    if (ctrl_q) begin
      return 1'b0;
    end
    ch = v;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  task automatic set_idling(input int unsigned gmax, input int unsigned bmax,
                            input stall_mode_e smode, input int unsigned spct);
    gap_max = gmax;
    burst_max = bmax;
    burst_left = 0;
    stall_mode = smode;
    stall_pct = spct;
  endtask

  task automatic send_scan(input byte_t code);
    byte_t ch;
    if (gap_max != 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      burst_left = $urandom_range(burst_max, 0);
    end else if (burst_left != 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_scan_byte <= code;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (decode_scan(code, ch)) begin
      char_expect_q.push_back(ch);
    end
  endtask

  function automatic byte_t pick_letter_scan();
    case ($urandom_range(2))
      0: return byte_t'($urandom_range(8'h19, 8'h10));
      1: return byte_t'($urandom_range(8'h26, 8'h1E));
      default: return byte_t'($urandom_range(8'h32, 8'h2C));
    endcase
  endfunction

  function automatic byte_t pick_typing_scan();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) begin
      return byte_t'($urandom_range(127));
    end else if (r < 60) begin
      return pick_letter_scan();
    end else if (r < 70) begin
      case ($urandom_range(3))
        0: return KEY_LSHIFT;
        1: return KEY_RSHIFT;
        2: return KEY_CTRL;
        default: return KEY_CAPS;
      endcase
    end else if (r < 82) begin
      case ($urandom_range(2))
        0: return REL_LSHIFT;
        1: return REL_RSHIFT;
        default: return REL_CTRL;
      endcase
    end else if (r < 92) begin
      return byte_t'($urandom_range(255));
    end
    case ($urandom_range(5))
      0: return KEY_UP;
      1: return KEY_LEFT;
      2: return KEY_RIGHT;
      3: return KEY_DOWN;
      4: return KEY_ESC;
      default: return KEY_ALT;
    endcase
  endfunction

  task automatic test_directed_keys();
    set_idling(2, 3, STALL_RANDOM, 30);
    foreach (DIRECTED_KEYS[i]) begin
      send_scan(DIRECTED_KEYS[i]);
    end
  endtask

  // The receiver holds off while letters keep coming, so the block fills and stalls.
  task automatic test_backpressure();
    set_idling(0, 0, STALL_NONE, 0);
    hold_req = 1'b1;
    repeat (30) send_scan(pick_letter_scan());
  endtask

  task automatic test_random_typing();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_idling(0, 0, STALL_NONE, 0);
        1: set_idling(3, 8, STALL_RANDOM, 25);
        2: set_idling(12, 2, STALL_RANDOM, 60);
        3: set_idling(1, 0, STALL_PATTERN, 0);
        4: set_idling(0, 0, STALL_RANDOM, 80);
        default: set_idling(6, 20, STALL_PATTERN, 0);
      endcase
      repeat (300) send_scan(pick_typing_scan());
    end
  endtask

  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      case (stall_mode)
        STALL_RANDOM: out_stall <= ($urandom_range(99) < stall_pct);
        STALL_PATTERN: out_stall <= ((pat_cnt % 7) >= 4);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (char_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, char_code %h", out_char_code));
      end else begin
        exp_char = char_expect_q.pop_front();
        if (out_char_code !== exp_char) begin
          report_mismatch($sformatf("char_code got %h expected %h",
                                    out_char_code, exp_char));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_scancode_to_char_decoder_unit: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_keys();
    test_backpressure();
    test_random_typing();
    in_valid <= 1'b0;
    while (char_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_scancode_to_char_decoder_unit: done, clean");
    end else begin
      $display("tb_scancode_to_char_decoder_unit: done, errors");
    end
    $finish;
  end

endmodule
